/* hdl/cpu_alu_pkg.sv */
package cpu_alu_pkg;

	localparam int CMD_W  = 5;
	localparam int DATA_W = 16;
	localparam int BYTE_W = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 5'd0,
		CMD_ADC   = 5'd1,
		CMD_SUB   = 5'd2,
		CMD_SBC   = 5'd3,
		CMD_AND   = 5'd4,
		CMD_XOR   = 5'd5,
		CMD_OR    = 5'd6,
		CMD_CP    = 5'd7,
		CMD_INC8  = 5'd8,
		CMD_DEC8  = 5'd9,
		CMD_DAA   = 5'd10,
		CMD_CPL   = 5'd11,
		CMD_SCF   = 5'd12,
		CMD_CCF   = 5'd13,
		CMD_ADD16 = 5'd14,
		CMD_ADDSP = 5'd15,
		CMD_INC16 = 5'd16,
		CMD_DEC16 = 5'd17
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic subtract;
		logic half_carry;
		logic carry;
	} flags_t;

	localparam logic [BYTE_W-1:0] DAA_LOW_ADJ  = 8'h06;
	localparam logic [BYTE_W-1:0] DAA_HIGH_ADJ = 8'h60;
	localparam logic [BYTE_W-1:0] DAA_LIMIT    = 8'h99;
	localparam logic [3:0]        NIBBLE_LIMIT = 4'd9;

endpackage

/* hdl/cpu_alu_with_flags_unit.sv */
// ALU of an 8-bit handheld-console processor, with Z, N, H and C flag logic.
//
// Input channel (cmd_valid / cmd_stall): one beat carries a command, two 16-bit
// operands and the four incoming flags. A beat is taken at a rising edge where
// cmd_valid is high and cmd_stall is low.
// Result channel (res_valid / res_stall): one beat carries the result, the
// write-back mark and the four new flags, for every input beat, in order.
//
// A beat is captured in the input register, the ALU works on it while it
// sits there, and the outcome is then registered in the result register
// once that register can load. Throughput is one beat per cycle while the
// receiver does not stall, set by the single register-to-register ALU pass.
//
// While the receiver stalls with a result waiting, the result register holds
// and the input register keeps the next beat; cmd_stall rises only when both
// are full, so at most two beats are in flight. Reset (arst_n low) empties
// both registers at once; payload registers are not cleared.
module cpu_alu_with_flags_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  logic [cpu_alu_pkg::CMD_W-1:0]   command,
	input  logic [cpu_alu_pkg::DATA_W-1:0]  operand_a,
	input  logic [cpu_alu_pkg::DATA_W-1:0]  operand_b,
	input  logic                            zero_in,
	input  logic                            subtract_in,
	input  logic                            half_carry_in,
	input  logic                            carry_in,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [cpu_alu_pkg::DATA_W-1:0]  result,
	output logic                            write_back,
	output logic                            zero_out,
	output logic                            subtract_out,
	output logic                            half_carry_out,
	output logic                            carry_out
);
	import cpu_alu_pkg::*;

	// Input register.
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [DATA_W-1:0]   op_a_s1;
	logic [DATA_W-1:0]   op_b_s1;
	flags_t              flags_s1;

	// Result register.
	logic                valid_s2;
	logic [DATA_W-1:0]   result_s2;
	logic                wb_s2;
	flags_t              flags_s2;

	logic advance_s2;
	logic advance_s1;

	// The result register may load when it is empty or its beat is leaving.
	assign advance_s2 = !valid_s2 || !res_stall;
	assign advance_s1 = !valid_s1 || advance_s2;
	assign cmd_stall  = !advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && cmd_valid) begin
			cmd_s1   <= cmd_t'(command);
			op_a_s1  <= operand_a;
			op_b_s1  <= operand_b;
			flags_s1 <= '{zero: zero_in, subtract: subtract_in,
				half_carry: half_carry_in, carry: carry_in};
		end
	end

	// ALU datapath. Byte commands look only at the low byte of each operand.
	logic [BYTE_W-1:0]   a8;
	logic [BYTE_W-1:0]   b8;
	logic                carry_sel;
	logic [BYTE_W:0]     add9;
	logic [4:0]          add_nib;
	logic [BYTE_W:0]     sub9;
	logic [4:0]          sub_nib;
	logic [DATA_W:0]     add17;
	logic [DATA_W-1:0]   sp_sum;
	logic [BYTE_W:0]     sp_low9;
	logic [4:0]          sp_nib;
	logic [BYTE_W-1:0]   inc8;
	logic [BYTE_W-1:0]   dec8;
	logic [BYTE_W-1:0]   daa_val;
	logic                daa_carry;
	logic [DATA_W-1:0]   alu_res;
	logic                alu_wb;
	flags_t              alu_flags;

	assign a8        = op_a_s1[BYTE_W-1:0];
	assign b8        = op_b_s1[BYTE_W-1:0];
	// ADC and SBC fold the incoming carry into the low bit.
	assign carry_sel = (cmd_s1 == CMD_ADC || cmd_s1 == CMD_SBC) ? flags_s1.carry : 1'b0;

	assign add9    = {1'b0, a8} + {1'b0, b8} + {{BYTE_W{1'b0}}, carry_sel};
	assign add_nib = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, carry_sel};
	// The top bit of a widened difference is the borrow out.
	assign sub9    = {1'b0, a8} - {1'b0, b8} - {{BYTE_W{1'b0}}, carry_sel};
	assign sub_nib = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, carry_sel};
	assign add17   = {1'b0, op_a_s1} + {1'b0, op_b_s1};
	assign sp_sum  = op_a_s1 + {{(DATA_W-BYTE_W){b8[BYTE_W-1]}}, b8};
	assign sp_low9 = {1'b0, a8} + {1'b0, b8};
	assign sp_nib  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
	assign inc8    = a8 + 8'd1;
	assign dec8    = a8 - 8'd1;

	// Decimal adjust: the correction direction follows the subtract flag.
	always_comb begin
		daa_val   = a8;
		daa_carry = flags_s1.carry;
		if (flags_s1.subtract) begin
			if (flags_s1.half_carry) daa_val = daa_val - DAA_LOW_ADJ;
			if (flags_s1.carry)      daa_val = daa_val - DAA_HIGH_ADJ;
		end else begin
			if (flags_s1.half_carry || a8[3:0] > NIBBLE_LIMIT) begin
				daa_val = daa_val + DAA_LOW_ADJ;
			end
			if (flags_s1.carry || a8 > DAA_LIMIT) begin
				daa_val   = daa_val + DAA_HIGH_ADJ;
				daa_carry = 1'b1;
			end
		end
	end

	always_comb begin
		alu_res   = '0;
		alu_wb    = 1'b1;
		alu_flags = flags_s1;
		unique case (cmd_s1)
			CMD_ADD, CMD_ADC: begin
				alu_res   = {8'd0, add9[BYTE_W-1:0]};
				alu_flags = '{zero: add9[BYTE_W-1:0] == '0, subtract: 1'b0,
					half_carry: add_nib[4], carry: add9[BYTE_W]};
			end
			CMD_SUB, CMD_SBC, CMD_CP: begin
				alu_flags = '{zero: sub9[BYTE_W-1:0] == '0, subtract: 1'b1,
					half_carry: sub_nib[4], carry: sub9[BYTE_W]};
				// Compare keeps only the flags.
				if (cmd_s1 == CMD_CP) begin
					alu_wb = 1'b0;
				end else begin
					alu_res = {8'd0, sub9[BYTE_W-1:0]};
				end
			end
			CMD_AND: begin
				alu_res   = {8'd0, a8 & b8};
				alu_flags = '{zero: (a8 & b8) == '0, subtract: 1'b0,
					half_carry: 1'b1, carry: 1'b0};
			end
			CMD_XOR: begin
				alu_res   = {8'd0, a8 ^ b8};
				alu_flags = '{zero: (a8 ^ b8) == '0, subtract: 1'b0,
					half_carry: 1'b0, carry: 1'b0};
			end
			CMD_OR: begin
				alu_res   = {8'd0, a8 | b8};
				alu_flags = '{zero: (a8 | b8) == '0, subtract: 1'b0,
					half_carry: 1'b0, carry: 1'b0};
			end
			CMD_INC8: begin
				alu_res              = {8'd0, inc8};
				alu_flags.zero       = inc8 == '0;
				alu_flags.subtract   = 1'b0;
				alu_flags.half_carry = inc8[3:0] == 4'h0;
			end
			CMD_DEC8: begin
				alu_res              = {8'd0, dec8};
				alu_flags.zero       = dec8 == '0;
				alu_flags.subtract   = 1'b1;
				alu_flags.half_carry = dec8[3:0] == 4'hF;
			end
			CMD_DAA: begin
				alu_res              = {8'd0, daa_val};
				alu_flags.zero       = daa_val == '0;
				alu_flags.half_carry = 1'b0;
				alu_flags.carry      = daa_carry;
			end
			CMD_CPL: begin
				alu_res              = {8'd0, ~a8};
				alu_flags.subtract   = 1'b1;
				alu_flags.half_carry = 1'b1;
			end
			CMD_SCF, CMD_CCF: begin
				alu_wb               = 1'b0;
				alu_flags.subtract   = 1'b0;
				alu_flags.half_carry = 1'b0;
				alu_flags.carry      = (cmd_s1 == CMD_SCF) ? 1'b1 : !flags_s1.carry;
			end
			CMD_ADD16: begin
				alu_res              = add17[DATA_W-1:0];
				alu_flags.subtract   = 1'b0;
				// Half carry of a 16-bit add comes out of bit 11.
				alu_flags.half_carry = op_a_s1[12] ^ op_b_s1[12] ^ add17[12];
				alu_flags.carry      = add17[DATA_W];
			end
			CMD_ADDSP: begin
				alu_res   = sp_sum;
				alu_flags = '{zero: 1'b0, subtract: 1'b0,
					half_carry: sp_nib[4], carry: sp_low9[BYTE_W]};
			end
			CMD_INC16: alu_res = op_a_s1 + 16'd1;
			CMD_DEC16: alu_res = op_a_s1 - 16'd1;
			default: begin
				// Undefined commands pass the flags and write nothing.
				alu_wb = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			result_s2 <= alu_res;
			wb_s2     <= alu_wb;
			flags_s2  <= alu_flags;
		end
	end

	assign res_valid      = valid_s2;
	assign result         = result_s2;
	assign write_back     = wb_s2;
	assign zero_out       = flags_s2.zero;
	assign subtract_out   = flags_s2.subtract;
	assign half_carry_out = flags_s2.half_carry;
	assign carry_out      = flags_s2.carry;

endmodule

/* hdl/cpu_alu_chk.sv */
module cpu_alu_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cmd_valid,
	input logic                            cmd_stall,
	input logic                            res_valid,
	input logic                            res_stall,
	input logic [cpu_alu_pkg::DATA_W-1:0]  result,
	input logic                            write_back,
	input logic                            zero_out,
	input logic                            subtract_out,
	input logic                            half_carry_out,
	input logic                            carry_out
);
	import cpu_alu_pkg::*;

	// A stalled result beat stays and keeps its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(result) && $stable(write_back)
			&& $stable({zero_out, subtract_out, half_carry_out, carry_out}))
		else $error("result beat changed while stalled");

	// The input side only backs up when a result is waiting on a stalled receiver.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("input stalled without a stalled result");

	// An accepted beat reaches the output if the receiver does not stall while it is in the input register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall ##1 !res_stall |=> res_valid)
		else $error("accepted beat did not arrive at the output");

	// Commands that write nothing back report a zero result.
	a_no_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !write_back |-> result == '0)
		else $error("nonzero result without write-back");

endmodule

bind cpu_alu_with_flags_unit cpu_alu_chk u_chk (.*);

/* tb/sv/tb_cpu_alu_with_flags_unit.sv */
module tb_cpu_alu_with_flags_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cpu_alu_pkg::*;

	// Command codes above the last defined operation. The ALU must treat them
	// as no-ops: nothing is written back and the flags pass through.
	localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 5'd18;
	localparam logic [CMD_W-1:0] CMD_LAST_CODE    = 5'd31;

	localparam int RANDOM_OPS      = 620;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int PRINT_LIMIT     = 40;

	// One result beat as the ALU should present it.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              wb;
		flags_t            flags;
	} alu_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	logic [CMD_W-1:0]     command = '0;
	logic [DATA_W-1:0]    operand_a = '0;
	logic [DATA_W-1:0]    operand_b = '0;
	logic                 zero_in = 1'b0;
	logic                 subtract_in = 1'b0;
	logic                 half_carry_in = 1'b0;
	logic                 carry_in = 1'b0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [DATA_W-1:0]    result;
	logic                 write_back;
	logic                 zero_out;
	logic                 subtract_out;
	logic                 half_carry_out;
	logic                 carry_out;

	// Results that the ALU owes us, oldest first. A beat is predicted the
	// moment its command is accepted, so this queue always mirrors the
	// contents of the pipeline.
	alu_out_t alu_results_owed[$];

	int  mismatch_count = 0;
	int  results_seen   = 0;
	int  cycle_count    = 0;
	// When set, neither side inserts idle cycles; used for back-to-back phases.
	bit  quiet          = 1'b0;
	// Asks the receiver process for one long stall.
	bit  hold_off_req   = 1'b0;

	cpu_alu_with_flags_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.command        (command),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.zero_in        (zero_in),
		.subtract_in    (subtract_in),
		.half_carry_in  (half_carry_in),
		.carry_in       (carry_in),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.result         (result),
		.write_back     (write_back),
		.zero_out       (zero_out),
		.subtract_out   (subtract_out),
		.half_carry_out (half_carry_out),
		.carry_out      (carry_out)
	);

	// 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog. Even the slowest legal run is far below this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Computes what the ALU should produce for one command. Byte operations
	// only look at the low byte of each operand; 16-bit operations keep Z
	// (except the stack offset add, which clears it) and INC16/DEC16 leave
	// every flag alone.
	function automatic alu_out_t alu_predict(logic [CMD_W-1:0] code, logic [DATA_W-1:0] a16,
			logic [DATA_W-1:0] b16, flags_t f);
		alu_out_t          o;
		logic [7:0]        a;
		logic [7:0]        b;
		logic [7:0]        v;
		logic              ci;
		logic [8:0]        wide9;
		logic [4:0]        nib;
		logic [16:0]       wide17;
		logic [DATA_W-1:0] carries;
		a = a16[7:0];
		b = b16[7:0];
		o.value = '0;
		o.wb = 1'b1;
		o.flags = f;
		case (cmd_t'(code))
			CMD_ADD, CMD_ADC: begin
				ci = (code == CMD_ADC) ? f.carry : 1'b0;
				wide9 = {1'b0, a} + {1'b0, b} + ci;
				nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + ci;
				o.value = {8'h00, wide9[7:0]};
				o.flags.zero = (wide9[7:0] == 8'h00);
				o.flags.subtract = 1'b0;
				o.flags.half_carry = nib[4];
				o.flags.carry = wide9[8];
			end
			CMD_SUB, CMD_SBC, CMD_CP: begin
				// A borrow shows up as the ninth (or fifth) bit of the difference.
				ci = (code == CMD_SBC) ? f.carry : 1'b0;
				wide9 = {1'b0, a} - {1'b0, b} - ci;
				nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - ci;
				o.value = {8'h00, wide9[7:0]};
				o.flags.zero = (wide9[7:0] == 8'h00);
				o.flags.subtract = 1'b1;
				o.flags.half_carry = nib[4];
				o.flags.carry = wide9[8];
				if (code == CMD_CP) begin
					o.value = '0;
					o.wb = 1'b0;
				end
			end
			CMD_AND, CMD_XOR, CMD_OR: begin
				if (code == CMD_AND)
					v = a & b;
				else if (code == CMD_XOR)
					v = a ^ b;
				else
					v = a | b;
				o.value = {8'h00, v};
				o.flags.zero = (v == 8'h00);
				o.flags.subtract = 1'b0;
				o.flags.half_carry = (code == CMD_AND);
				o.flags.carry = 1'b0;
			end
			CMD_INC8: begin
				v = a + 8'd1;
				o.value = {8'h00, v};
				o.flags.zero = (v == 8'h00);
				o.flags.subtract = 1'b0;
				o.flags.half_carry = (v[3:0] == 4'h0);
			end
			CMD_DEC8: begin
				v = a - 8'd1;
				o.value = {8'h00, v};
				o.flags.zero = (v == 8'h00);
				o.flags.subtract = 1'b1;
				o.flags.half_carry = (v[3:0] == 4'hF);
			end
			CMD_DAA: begin
				v = a;
				if (f.subtract) begin
					if (f.half_carry)
						v = v - DAA_LOW_ADJ;
					if (f.carry)
						v = v - DAA_HIGH_ADJ;
				end else begin
					if (f.half_carry || a[3:0] > NIBBLE_LIMIT)
						v = v + DAA_LOW_ADJ;
					if (f.carry || a > DAA_LIMIT) begin
						v = v + DAA_HIGH_ADJ;
						o.flags.carry = 1'b1;
					end
				end
				o.value = {8'h00, v};
				o.flags.zero = (v == 8'h00);
				o.flags.half_carry = 1'b0;
			end
			CMD_CPL: begin
				o.value = {8'h00, ~a};
				o.flags.subtract = 1'b1;
				o.flags.half_carry = 1'b1;
			end
			CMD_SCF, CMD_CCF: begin
				o.wb = 1'b0;
				o.flags.subtract = 1'b0;
				o.flags.half_carry = 1'b0;
				o.flags.carry = (code == CMD_SCF) ? 1'b1 : ~f.carry;
			end
			CMD_ADD16: begin
				wide17 = {1'b0, a16} + {1'b0, b16};
				carries = a16 ^ b16 ^ wide17[15:0];
				o.value = wide17[15:0];
				o.flags.subtract = 1'b0;
				o.flags.half_carry = carries[12];
				o.flags.carry = wide17[16];
			end
			CMD_ADDSP: begin
				// Flags come from an unsigned add on the low byte, the value from
				// the sign-extended offset.
				wide9 = {1'b0, a16[7:0]} + {1'b0, b};
				nib = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
				o.value = a16 + {{8{b[7]}}, b};
				o.flags.zero = 1'b0;
				o.flags.subtract = 1'b0;
				o.flags.half_carry = nib[4];
				o.flags.carry = wide9[8];
			end
			CMD_INC16: o.value = a16 + 16'd1;
			CMD_DEC16: o.value = a16 - 16'd1;
			default: begin
				o.value = '0;
				o.wb = 1'b0;
			end
		endcase
		return o;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Operand with a bias toward the corners of the range.
	function automatic logic [DATA_W-1:0] pick_operand();
		int r;
		r = $urandom_range(0, 11);
		case (r)
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return {8'($urandom), 8'h00};
			3: return {8'($urandom), 8'hFF};
			4: return {8'($urandom), 8'h80};
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] pick_command();
		if ($urandom_range(0, 19) == 0)
			return CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
		return CMD_W'($urandom_range(CMD_ADD, CMD_DEC16));
	endfunction

	// Random incoming flags.
	function automatic flags_t pick_flags();
		return flags_t'(4'($urandom_range(0, 15)));
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns: result beat %0d, %s: got %h, expected %h",
				$time, results_seen, what, got, want);
		mismatch_count++;
	endtask

	// Presents one command beat and holds it until the ALU takes it. The
	// expectation is queued at the accepting edge. Valid stays high when no
	// gap follows, so back-to-back beats never drop valid between them.
	task automatic send_op(logic [CMD_W-1:0] code, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
			flags_t f);
		int gap;
		command       <= code;
		operand_a     <= a;
		operand_b     <= b;
		zero_in       <= f.zero;
		subtract_in   <= f.subtract;
		half_carry_in <= f.half_carry;
		carry_in      <= f.carry;
		cmd_valid     <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
		alu_results_owed.push_back(alu_predict(code, a, b, f));
		gap = quiet ? 0 : idle_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering commands and waits until every owed result is back.
	task automatic wait_results_drained();
		cmd_valid <= 1'b0;
		while (alu_results_owed.size() != 0)
			@(posedge clk);
	endtask

	// Hand-picked beats: every operation, carry and borrow corners, the
	// ignored upper operand bytes, both directions of decimal adjust, the
	// bit-11 carry of the 16-bit add, a negative stack offset, and unused codes.
	task automatic test_directed();
		send_op(CMD_ADD,   16'hAB00, 16'hCD00, flags_t'(4'b1111));
		send_op(CMD_ADD,   16'h00FF, 16'h0001, flags_t'(4'b0000));
		send_op(CMD_ADC,   16'h000F, 16'h0000, flags_t'(4'b0001));
		send_op(CMD_SUB,   16'h0000, 16'h0001, flags_t'(4'b0000));
		send_op(CMD_SBC,   16'hFF10, 16'h000F, flags_t'(4'b0001));
		send_op(CMD_AND,   16'h12FF, 16'h3400, flags_t'(4'b0101));
		send_op(CMD_XOR,   16'h00FF, 16'hFFFF, flags_t'(4'b1111));
		send_op(CMD_OR,    16'hFF00, 16'hFF00, flags_t'(4'b0000));
		send_op(CMD_CP,    16'h0042, 16'h0042, flags_t'(4'b0000));
		send_op(CMD_CP,    16'h0000, 16'h00FF, flags_t'(4'b1000));
		send_op(CMD_INC8,  16'hFFFF, 16'h0000, flags_t'(4'b0001));
		send_op(CMD_DEC8,  16'h0000, 16'h0000, flags_t'(4'b0000));
		send_op(CMD_DEC8,  16'h0010, 16'h0000, flags_t'(4'b1001));
		// Decimal adjust after an add that overflowed both digits, after an add with
		// both carry flags set, then after a subtraction with both borrows.
		send_op(CMD_DAA,   16'h009A, 16'h0000, flags_t'(4'b0000));
		send_op(CMD_DAA,   16'h0045, 16'h0000, flags_t'(4'b0011));
		send_op(CMD_DAA,   16'h0066, 16'h0000, flags_t'(4'b0111));
		send_op(CMD_CPL,   16'hF05A, 16'h0000, flags_t'(4'b1001));
		send_op(CMD_SCF,   16'h1234, 16'h5678, flags_t'(4'b1110));
		send_op(CMD_CCF,   16'h1234, 16'h5678, flags_t'(4'b0111));
		send_op(CMD_ADD16, 16'h0FFF, 16'h0001, flags_t'(4'b1000));
		send_op(CMD_ADD16, 16'hFFFF, 16'hFFFF, flags_t'(4'b0000));
		send_op(CMD_ADDSP, 16'h00FF, 16'h1280, flags_t'(4'b1100));
		send_op(CMD_ADDSP, 16'hFFF8, 16'h0008, flags_t'(4'b1111));
		send_op(CMD_INC16, 16'hFFFF, 16'h0000, flags_t'(4'b1010));
		send_op(CMD_DEC16, 16'h0000, 16'hFFFF, flags_t'(4'b0101));
		send_op(CMD_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, flags_t'(4'b1111));
		send_op(CMD_LAST_CODE,    16'h5555, 16'hAAAA, flags_t'(4'b0110));
	endtask

	// Random commands with random operands and flags. In every 150 beats a
	// stretch of 30 beats runs with no idling on either side.
	task automatic test_random_ops();
		for (int i = 0; i < RANDOM_OPS; i++) begin
			quiet = (i % 150) >= 120;
			send_op(pick_command(), pick_operand(), pick_operand(), pick_flags());
		end
		quiet = 1'b0;
	endtask

	// The receiver holds off for a long stretch while commands keep coming,
	// so both pipeline stages fill and cmd_stall must rise.
	task automatic test_result_hold_off();
		quiet = 1'b1;
		hold_off_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_op(pick_command(), pick_operand(), pick_operand(), pick_flags());
		quiet = 1'b0;
	endtask

	// The sender pauses until the pipeline is empty, then starts again from
	// an idle ALU.
	task automatic test_pause_until_drained();
		for (int round = 0; round < 2; round++) begin
			for (int i = 0; i < 10; i++)
				send_op(pick_command(), pick_operand(), pick_operand(), pick_flags());
			wait_results_drained();
		end
	endtask

	// Receiver: alternates random stall stretches with runs of readiness.
	// A pending hold-off request turns the next stall into a long one.
	initial begin : result_receiver
		int stall_len;
		int run_len;
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				stall_len = quiet ? 0 : idle_len();
				if (stall_len > 0) begin
					res_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
			end
			res_stall <= 1'b0;
			run_len = quiet ? 8 : $urandom_range(1, 6);
			repeat (run_len) @(posedge clk);
		end
	end

	// Checker: each accepted result beat is compared with the oldest owed one.
	always @(posedge clk) begin : result_check
		alu_out_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (alu_results_owed.size() == 0) begin
				report_mismatch("unexpected beat, result", result, '0);
			end else begin
				want = alu_results_owed.pop_front();
				if (result !== want.value)
					report_mismatch("result", result, want.value);
				if (write_back !== want.wb)
					report_mismatch("write_back", DATA_W'(write_back), DATA_W'(want.wb));
				if (zero_out !== want.flags.zero)
					report_mismatch("zero_out", DATA_W'(zero_out),
						DATA_W'(want.flags.zero));
				if (subtract_out !== want.flags.subtract)
					report_mismatch("subtract_out", DATA_W'(subtract_out),
						DATA_W'(want.flags.subtract));
				if (half_carry_out !== want.flags.half_carry)
					report_mismatch("half_carry_out", DATA_W'(half_carry_out),
						DATA_W'(want.flags.half_carry));
				if (carry_out !== want.flags.carry)
					report_mismatch("carry_out", DATA_W'(carry_out),
						DATA_W'(want.flags.carry));
			end
			results_seen++;
		end
	end

	// Test sequence. Reset is held at the start and never asserted again.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_ops();
		test_result_hold_off();
		test_pause_until_drained();
		wait_results_drained();
		// Keep clocking after the drain so a stray extra beat would still be caught.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
